// ===== rtl/blr_pkg.sv =====
// Shared constants and types for the bounded random generator.
`default_nettype none
package blr_pkg;

	// Generator step: state = state * LCG_MULT + LCG_ADD mod 2^48
	localparam int STATE_W   = 48;
	localparam int MULT_BITS = 35;
	localparam logic [MULT_BITS-1:0] LCG_MULT = 35'h5DEECE66D;
	localparam logic [STATE_W-1:0]   LCG_ADD  = 48'hB;
	localparam int MCNT_W    = $clog2(MULT_BITS);

	// Draw taken from the top bits of the new state
	localparam int DRAW_W    = 31;
	localparam int DRAW_LSB  = STATE_W - DRAW_W;
	localparam int DCNT_W    = $clog2(DRAW_W);

	// Bound and range widths
	localparam int BOUND_W   = 32;
	localparam int RANGE_W   = BOUND_W + 1;
	localparam logic [RANGE_W-1:0] DRAW_SPAN = RANGE_W'(64'h8000_0000);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LCG_GO,
		ST_LCG_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_CHECK,
		ST_DONE
	} blr_state_t;

endpackage
`default_nettype wire

// ===== rtl/blr_lcg.sv =====
// Bit-serial 48-bit LCG step: one multiplier bit per cycle, shift and add.
`default_nettype none
module blr_lcg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire logic [blr_pkg::STATE_W-1:0]   load_val,
	input  wire logic                          start,
	output logic [blr_pkg::STATE_W-1:0]        state,
	output logic                               done
);

	localparam logic [blr_pkg::MCNT_W-1:0] LAST = blr_pkg::MCNT_W'(blr_pkg::MULT_BITS - 1);

	logic [blr_pkg::STATE_W-1:0] state_q;
	logic [blr_pkg::STATE_W-1:0] acc_q;
	logic [blr_pkg::STATE_W-1:0] mcand_q;
	logic [blr_pkg::STATE_W-1:0] acc_sum;
	logic [blr_pkg::MCNT_W-1:0]  cnt_q;
	logic                        busy_q;

	// add the shifted multiplicand when this multiplier bit is set
	always_comb begin
		acc_sum = blr_pkg::LCG_MULT[cnt_q] ? acc_q + mcand_q : acc_q;
	end

	// control and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			busy_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (load) begin
				state_q <= load_val;
			end
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + blr_pkg::MCNT_W'(1);
				if (cnt_q == LAST) begin
					busy_q  <= 1'b0;
					state_q <= acc_sum;
				end
			end
		end
	end

	// accumulator and shifted multiplicand
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= blr_pkg::LCG_ADD;
			mcand_q <= state_q;
		end else if (busy_q) begin
			acc_q   <= acc_sum;
			mcand_q <= {mcand_q[blr_pkg::STATE_W-2:0], 1'b0};
		end
	end

	assign state = state_q;
	assign done  = busy_q && (cnt_q == LAST);

endmodule
`default_nettype wire

// ===== rtl/blr_div.sv =====
// Restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module blr_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [blr_pkg::DRAW_W-1:0]    dividend,
	input  wire logic [blr_pkg::RANGE_W-1:0]   divisor,
	output logic [blr_pkg::RANGE_W-1:0]        rem,
	output logic                               done
);

	localparam logic [blr_pkg::DCNT_W-1:0] LAST = blr_pkg::DCNT_W'(blr_pkg::DRAW_W - 1);

	logic [blr_pkg::DRAW_W-1:0]  quo_q;
	logic [blr_pkg::RANGE_W-1:0] div_q;
	logic [blr_pkg::RANGE_W-1:0] rem_q;
	logic [blr_pkg::RANGE_W-1:0] rem_next;
	logic [blr_pkg::RANGE_W:0]   trial;
	logic [blr_pkg::RANGE_W:0]   diff;
	logic [blr_pkg::DCNT_W-1:0]  cnt_q;
	logic                        busy_q;

	// shift in next dividend bit, subtract when it fits
	always_comb begin
		trial    = {rem_q, quo_q[blr_pkg::DRAW_W-1]};
		diff     = trial - {1'b0, div_q};
		rem_next = (trial >= {1'b0, div_q}) ? diff[blr_pkg::RANGE_W-1:0]
		                                    : trial[blr_pkg::RANGE_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + blr_pkg::DCNT_W'(1);
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[blr_pkg::DRAW_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rem  = rem_q;
	assign done = busy_q && (cnt_q == LAST);

endmodule
`default_nettype wire

// ===== rtl/bounded_random_lcg48.sv =====
// Bounded random generator: sequencer, LCG step unit, remainder unit, result register.
// Each draw runs the bit-serial 35-bit constant multiply of the LCG step, then the
// bit-serial 31-bit remainder, then the reject check.
// A valid item makes one draw, and one more each time a draw is rejected.
// Inverted bounds make no draw and go straight to the result.
// One item is worked on at a time; the next is taken while a result waits to be taken.
// Reset clears the generator state to zero (the seed reset value) and drops all valids.
`default_nettype none
module bounded_random_lcg48 (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// seed write channel
	input  wire logic                          seed_valid,
	output logic                               seed_ready,
	input  wire logic [blr_pkg::STATE_W-1:0]   seed,
	// request channel
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic [blr_pkg::BOUND_W-1:0]   lower_bound,
	input  wire logic [blr_pkg::BOUND_W-1:0]   upper_bound,
	// response channel
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic [blr_pkg::BOUND_W-1:0]        value,
	output logic                               bad_bounds
);

	blr_pkg::blr_state_t state_q, state_d;

	logic [blr_pkg::BOUND_W-1:0] lo_q;
	logic [blr_pkg::RANGE_W-1:0] range_q;
	logic [blr_pkg::BOUND_W-1:0] res_value_q;
	logic                        res_bad_q;
	logic                        out_valid_q;
	logic [blr_pkg::BOUND_W-1:0] out_value_q;
	logic                        out_bad_q;

	logic                        req_acc;
	logic                        seed_wr;
	logic                        lcg_start;
	logic                        lcg_done;
	logic [blr_pkg::STATE_W-1:0] gen_state;
	logic                        div_start;
	logic                        div_done;
	logic [blr_pkg::RANGE_W-1:0] rem;
	logic [blr_pkg::DRAW_W-1:0]  draw;
	logic [blr_pkg::DRAW_W-1:0]  draw_less_rem;
	logic [blr_pkg::BOUND_W-1:0] reject_lim;
	logic                        reject;
	logic                        out_free;

	assign seed_ready = (state_q == blr_pkg::ST_IDLE);
	assign seed_wr    = seed_valid && seed_ready;
	assign req_stall  = (state_q != blr_pkg::ST_IDLE);
	assign req_acc    = req_valid && !req_stall;
	assign out_free   = !out_valid_q || !rsp_stall;

	assign draw = gen_state[blr_pkg::STATE_W-1:blr_pkg::DRAW_LSB];

	// generator step unit
	blr_lcg u_lcg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (seed_wr),
		.load_val (seed),
		.start    (lcg_start),
		.state    (gen_state),
		.done     (lcg_done)
	);

	// draw modulo range
	blr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (draw),
		.divisor  (range_q),
		.rem      (rem),
		.done     (div_done)
	);

	// debias check: reject when draw - rem exceeds 2^31 - range, for range <= 2^31
	always_comb begin
		draw_less_rem = draw - rem[blr_pkg::DRAW_W-1:0];
		reject_lim    = blr_pkg::DRAW_SPAN[blr_pkg::BOUND_W-1:0]
		                - range_q[blr_pkg::BOUND_W-1:0];
		reject        = (range_q <= blr_pkg::DRAW_SPAN)
		                && ({1'b0, draw_less_rem} > reject_lim);
	end

	// next state and unit starts
	always_comb begin
		state_d   = state_q;
		lcg_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			blr_pkg::ST_IDLE: begin
				if (req_acc) begin
					state_d = (lower_bound > upper_bound) ? blr_pkg::ST_DONE
					                                       : blr_pkg::ST_LCG_GO;
				end
			end
			blr_pkg::ST_LCG_GO: begin
				lcg_start = 1'b1;
				state_d   = blr_pkg::ST_LCG_WAIT;
			end
			blr_pkg::ST_LCG_WAIT: begin
				if (lcg_done) begin
					state_d = blr_pkg::ST_DIV_GO;
				end
			end
			blr_pkg::ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = blr_pkg::ST_DIV_WAIT;
			end
			blr_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = blr_pkg::ST_CHECK;
				end
			end
			blr_pkg::ST_CHECK: begin
				state_d = reject ? blr_pkg::ST_LCG_GO : blr_pkg::ST_DONE;
			end
			blr_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = blr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = blr_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			lo_q        <= lower_bound;
			range_q     <= {1'b0, upper_bound} - {1'b0, lower_bound} + blr_pkg::RANGE_W'(1);
			res_value_q <= '0;
			res_bad_q   <= (lower_bound > upper_bound);
		end else if (state_q == blr_pkg::ST_CHECK && !reject) begin
			res_value_q <= lo_q + rem[blr_pkg::BOUND_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == blr_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == blr_pkg::ST_DONE && out_free) begin
			out_value_q <= res_value_q;
			out_bad_q   <= res_bad_q;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign value      = out_value_q;
	assign bad_bounds = out_bad_q;

	// step unit finishes only while the sequencer waits for it
	a_lcg_done: assert property (@(posedge clk) disable iff (!arst_n)
		lcg_done |-> (state_q == blr_pkg::ST_LCG_WAIT))
		else $error("LCG step finished outside its wait state");

	// remainder unit finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == blr_pkg::ST_DIV_WAIT))
		else $error("remainder finished outside its wait state");

	// remainder handed to the check is below the range
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == blr_pkg::ST_CHECK) |-> (rem < range_q))
		else $error("remainder not below range");

	// a bad-bounds result carries zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && bad_bounds) |-> (value == '0))
		else $error("bad-bounds result not zero");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 48-bit LCG bounded random generator.
module tb_top;

	// Generator step and debias threshold, kept independent of the package
	localparam logic [47:0] LCG_MUL     = 48'h5_DEEC_E66D;
	localparam logic [47:0] LCG_INC     = 48'hB;
	localparam logic [32:0] DRAW_LIMIT  = 33'h0_8000_0000;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int unsigned TAIL_CYCLES = 300;

	typedef struct packed {
		logic [31:0] value;
		logic        bad_bounds;
	} draw_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            seed_valid;
	logic                            seed_ready;
	logic [blr_pkg::STATE_W-1:0]     seed;
	logic                            req_valid;
	logic                            req_stall;
	logic [blr_pkg::BOUND_W-1:0]     lower_bound;
	logic [blr_pkg::BOUND_W-1:0]     upper_bound;
	logic                            rsp_valid;
	logic                            rsp_stall;
	logic [blr_pkg::BOUND_W-1:0]     value;
	logic                            bad_bounds;

	// Predictor state and expected results in arrival order
	logic [47:0]     lcg_state;
	draw_result_t    draws_due[$];
	int unsigned     mismatch_count = 0;
	int unsigned     cycle_count = 0;
	bit              req_held = 1'b0;
	bit              send_gaps_on = 1'b1;
	bit              rsp_gaps_on = 1'b1;
	int unsigned     rsp_hold_left = 0;

	bounded_random_lcg48 dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed_valid  (seed_valid),
		.seed_ready  (seed_ready),
		.seed        (seed),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.lower_bound (lower_bound),
		.upper_bound (upper_bound),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.value       (value),
		.bad_bounds  (bad_bounds)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	// Expected result of one request; steps the predicted generator state
	function automatic void predict_bounded_draw(input logic [31:0] lo, input logic [31:0] hi,
		output draw_result_t res);
		logic [32:0] span;
		logic [32:0] draw;
		logic [32:0] rem;
		bit          redo;
		if (lo > hi) begin
			// inverted bounds: no draw, state untouched
			res.value      = '0;
			res.bad_bounds = 1'b1;
			return;
		end
		span = {1'b0, hi} - {1'b0, lo} + 33'd1;
		do begin
			lcg_state = lcg_state * LCG_MUL + LCG_INC;
			draw      = {2'b00, lcg_state[47:17]};
			rem       = draw % span;
			redo      = (span <= DRAW_LIMIT) && ((draw - rem) > (DRAW_LIMIT - span));
		end while (redo);
		res.value      = lo + rem[31:0];
		res.bad_bounds = 1'b0;
	endfunction

	// Offer one item and hold it until accepted, then an optional gap
	task automatic send_bounds(input logic [31:0] lo, input logic [31:0] hi);
		draw_result_t want;
		int unsigned  gap;
		req_valid   <= 1'b1;
		lower_bound <= lo;
		upper_bound <= hi;
		req_held     = 1'b1;
		do @(posedge clk); while (req_stall);
		predict_bounded_draw(lo, hi, want);
		draws_due.push_back(want);
		gap = send_gaps_on ? idle_len() : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			req_held   = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop the request and wait for every pending result
	task automatic drain_draws();
		if (req_held) begin
			req_valid <= 1'b0;
			req_held   = 1'b0;
		end
		while (draws_due.size() != 0) @(posedge clk);
	endtask

	// Seed write; only called with the block idle
	task automatic load_seed(input logic [47:0] s);
		seed_valid <= 1'b1;
		seed       <= s;
		do @(posedge clk); while (!seed_ready);
		lcg_state   = s;
		seed_valid <= 1'b0;
	endtask

	// Random bounds: mostly well-formed, with hard spans and some inverted pairs
	task automatic pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
		int unsigned kind;
		logic [31:0] span_lo;
		kind = $urandom_range(0, 99);
		lo   = $urandom;
		hi   = $urandom;
		if (kind < 20) begin
			// arbitrary pair, about half of them inverted
		end else if (kind < 45) begin
			if (lo > hi) begin
				span_lo = lo;
				lo      = hi;
				hi      = span_lo;
			end
		end else if (kind < 62) begin
			// tiny span
			hi = lo + 32'($urandom_range(0, 15));
			if (hi < lo) hi = 32'hFFFF_FFFF;
		end else if (kind < 74) begin
			// span around 2^31, on both sides of the debias limit
			span_lo = 32'h8000_0000 + 32'($urandom_range(0, 3)) - 32'd2;
			lo      = lo & 32'h7FFF_FFFF;
			hi      = lo + span_lo - 32'd1;
		end else if (kind < 88) begin
			// span just over 2^30: many redraws
			span_lo = 32'h4000_0000 + 32'($urandom_range(1, 1 << 20));
			lo      = lo & 32'h3FFF_FFFF;
			hi      = lo + span_lo - 32'd1;
		end else if (kind < 94) begin
			// inverted by one
			if (hi == 32'hFFFF_FFFF) hi = hi - 32'd1;
			lo = hi + 32'd1;
		end else begin
			hi = lo;
		end
	endtask

	// Response stall: random runs, or a long hold-off when requested
	initial begin : rsp_stall_gen
		int unsigned run_left;
		logic        level;
		run_left  = 0;
		level     = 1'b0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_left != 0) begin
				rsp_hold_left--;
				rsp_stall <= 1'b1;
			end else if (!rsp_gaps_on) begin
				rsp_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					level    = ($urandom_range(0, 99) < 35);
					run_left = level ? idle_len() + 1 : $urandom_range(1, 8);
				end
				run_left--;
				rsp_stall <= level;
			end
		end
	end

	// Result checker: each accepted item against the oldest expectation
	always @(posedge clk) begin
		draw_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (draws_due.size() == 0) begin
				$error("unexpected result: value %h bad_bounds %b", value, bad_bounds);
				mismatch_count++;
			end else begin
				want = draws_due.pop_front();
				if (value !== want.value) begin
					$error("value: expected %h, got %h", want.value, value);
					mismatch_count++;
				end
				if (bad_bounds !== want.bad_bounds) begin
					$error("bad_bounds: expected %b, got %b", want.bad_bounds, bad_bounds);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Field extremes and the special cases, from the reset seed
	task automatic test_directed_bounds();
		send_bounds(32'h0000_0000, 32'h0000_0000);
		send_bounds(32'h0000_0000, 32'hFFFF_FFFF);
		send_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_bounds(32'hFFFF_FFFF, 32'h0000_0000);
		send_bounds(32'h0000_0001, 32'h0000_0000);
		send_bounds(32'h0000_0005, 32'h0000_0005);
		send_bounds(32'h0000_0000, 32'h0000_0001);
		send_bounds(32'h0000_0000, 32'h7FFF_FFFF);
		send_bounds(32'h0000_0000, 32'h8000_0000);
		send_bounds(32'h0000_0000, 32'h3FFF_FFFF);
		send_bounds(32'h0000_0000, 32'h4000_0000);
		send_bounds(32'h8000_0000, 32'hFFFF_FFFF);
		send_bounds(32'h0000_0000, 32'h0000_0002);
		send_bounds(32'hAAAA_AAAA, 32'h5555_5555);
		send_bounds(32'h5555_5555, 32'hAAAA_AAAA);
		send_bounds(32'h1234_5678, 32'h1234_5679);
		send_bounds(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_bounds(32'h0000_0000, 32'h5FFF_FFFF);
		drain_draws();
	endtask

	// A few items under one seed
	task automatic run_seed_round(input logic [47:0] s);
		load_seed(s);
		send_bounds(32'h0000_0000, 32'hFFFF_FFFF);
		send_bounds(32'h0000_0000, 32'h4000_0000);
		send_bounds(32'hFFFF_FFFF, 32'h0000_0000);
		send_bounds(32'h0000_0010, 32'h0000_001F);
		drain_draws();
	endtask

	task automatic test_seed_extremes();
		run_seed_round(48'hFFFF_FFFF_FFFF);
		run_seed_round(48'h0000_0000_0000);
		run_seed_round(48'h0000_0000_0001);
		run_seed_round(48'hAAAA_AAAA_AAAA);
		run_seed_round(48'h5555_5555_5555);
	endtask

	// Receiver holds off long while items keep coming, so the input stalls
	task automatic test_output_backpressure();
		logic [31:0] lo;
		logic [31:0] hi;
		send_gaps_on  = 1'b0;
		rsp_hold_left = 600;
		repeat (12) begin
			pick_bounds(lo, hi);
			send_bounds(lo, hi);
		end
		drain_draws();
		send_gaps_on = 1'b1;
	endtask

	// Random phases, each with a fresh seed; the sender sometimes waits for the drain
	task automatic test_random_bounds();
		logic [31:0] lo;
		logic [31:0] hi;
		logic [63:0] wide;
		for (int phase = 0; phase < 6; phase++) begin
			send_gaps_on = (phase != 1);
			rsp_gaps_on  = (phase != 1);
			wide = {$urandom, $urandom};
			load_seed(wide[47:0]);
			for (int n = 0; n < 175; n++) begin
				pick_bounds(lo, hi);
				send_bounds(lo, hi);
				if ($urandom_range(0, 59) == 0) drain_draws();
			end
			drain_draws();
		end
		send_gaps_on = 1'b1;
		rsp_gaps_on  = 1'b1;
	endtask

	initial begin
		arst_n      = 1'b0;
		seed_valid  = 1'b0;
		seed        = '0;
		req_valid   = 1'b0;
		lower_bound = '0;
		upper_bound = '0;
		lcg_state   = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_bounds();
		test_seed_extremes();
		test_output_backpressure();
		test_random_bounds();
		drain_draws();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
